FILE: design/preemptive_priority_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define PPSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ppsu_pkg.sv
// ----------------------------------------------------------------------------
// ppsu_pkg
// Constants, codes and shared structs of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package ppsu_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 16;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SEQ_W     = 16;
    localparam int ID_W      = 8;
    localparam int BURST_W   = 12;
    localparam int PRIO_W    = 8;
    localparam int OUT_T_W   = 16;

    // input kinds
    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_ADMIT  = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_RAN    = 2'd2;
    localparam logic [1:0] STAT_IDLE   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ACT
    } state_t;

    // running process as seen by every cell
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } cur_t;

    // candidate handed from cell to cell
    typedef struct packed {
        logic                 free_found;
        logic [SLOT_W-1:0]    free_slot;
        logic                 best_found;
        logic                 inc;
        logic [SLOT_W-1:0]    slot;
        logic [PRIO_W-1:0]    prio;
        logic [SEQ_W-1:0]     age;
        logic [ID_W-1:0]      ident;
        logic [BURST_W-1:0]   remaining;
        logic [BURST_W-1:0]   burst;
        logic [TIME_BITS-1:0] admit;
        logic [TIME_BITS-1:0] first;
        logic                 started;
    } cand_t;

    // update broadcast to the cells
    typedef struct packed {
        logic                 admit;
        logic                 run;
        logic [SLOT_W-1:0]    slot;
        logic [ID_W-1:0]      ident;
        logic [BURST_W-1:0]   burst;
        logic [PRIO_W-1:0]    prio;
        logic [TIME_BITS-1:0] time_now;
        logic [SEQ_W-1:0]     seq;
    } cmd_t;

endpackage

FILE: design/ppsu_cell.sv
// ----------------------------------------------------------------------------
// ppsu_cell
// One process slot. Merges its slot into the candidate coming from the
// previous cell and registers the result for the next cell.
// ----------------------------------------------------------------------------
module ppsu_cell
    import ppsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] idx,
    input  cur_t              cur,
    input  logic [SEQ_W-1:0]  seq_now,
    input  cmd_t              cmd,
    input  cand_t             cand_in,
    output cand_t             cand_out,
    output logic              slot_valid
);

    logic                 valid_reg;
    logic                 started_reg;
    logic [ID_W-1:0]      ident_reg;
    logic [BURST_W-1:0]   remaining_reg;
    logic [BURST_W-1:0]   burst_reg;
    logic [PRIO_W-1:0]    prio_reg;
    logic [TIME_BITS-1:0] admit_reg;
    logic [TIME_BITS-1:0] first_reg;
    logic [SEQ_W-1:0]     seq_reg;
    cand_t                cand_reg;
    cand_t                cand_next;

    logic [SEQ_W-1:0] age;
    logic             is_cur;
    logic             better;
    logic             hit;
    logic             done;

    assign age    = seq_now - seq_reg;
    assign is_cur = cur.valid && (cur.slot == idx);
    assign hit    = (cmd.slot == idx);
    assign done   = (remaining_reg == BURST_W'(1));

    // incumbent wins equal priority; otherwise older admission wins
    assign better = valid_reg && (!cand_in.best_found
                  || (prio_reg < cand_in.prio)
                  || ((prio_reg == cand_in.prio) && !cand_in.inc
                      && (is_cur || (age > cand_in.age))));

    // merge own slot into the passing candidate
    always_comb
    begin
        cand_next = cand_in;
        if (!valid_reg && !cand_in.free_found)
        begin
            cand_next.free_found = 1'b1;
            cand_next.free_slot  = idx;
        end
        if (better)
        begin
            cand_next.best_found = 1'b1;
            cand_next.inc        = is_cur;
            cand_next.slot       = idx;
            cand_next.prio       = prio_reg;
            cand_next.age        = age;
            cand_next.ident      = ident_reg;
            cand_next.remaining  = remaining_reg;
            cand_next.burst      = burst_reg;
            cand_next.admit      = admit_reg;
            cand_next.first      = first_reg;
            cand_next.started    = started_reg;
        end
    end

    // advance the candidate chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    // slot occupancy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            started_reg <= 1'b0;
        end
        else if (hit && cmd.admit)
        begin
            valid_reg   <= 1'b1;
            started_reg <= 1'b0;
        end
        else if (hit && cmd.run)
        begin
            valid_reg   <= !done;
            started_reg <= !done;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        if (hit && cmd.admit)
        begin
            ident_reg     <= cmd.ident;
            remaining_reg <= cmd.burst;
            burst_reg     <= cmd.burst;
            prio_reg      <= cmd.prio;
            admit_reg     <= cmd.time_now;
            seq_reg       <= cmd.seq;
        end
        else if (hit && cmd.run)
        begin
            remaining_reg <= remaining_reg - BURST_W'(1);
            if (!started_reg)
            begin
                first_reg <= cmd.time_now;
            end
        end
    end

    assign cand_out   = cand_reg;
    assign slot_valid = valid_reg;

endmodule

FILE: design/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Tick-driven preemptive priority scheduler built on a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one item per transfer: tuser is the kind
//   (admit or tick), tdata the process id, burst and priority for an admit.
//   Output stream m_axis returns one result per item, in order: tuser is the
//   status, tdata the running id, finish flag and the three timing figures.
// Timing:
//   After a transfer the best candidate ripples through the SLOTS cells, one
//   cell per cycle, then the ACT state applies the update and loads the
//   result. A new item is taken only in the idle state, once the update of
//   the previous item has been applied.
// Reset:
//   All slots empty, no running process, time and admission count zero.
// Stall:
//   The result waits in the output register; the next item is still taken,
//   and its update holds until the output register is free.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_unit_assert.svh"

module preemptive_priority_scheduler_unit
    import ppsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // proc_id[7:0], burst[19:8], priority_req[27:20]
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // running_id, finished, finished_id, response,
                                       // waiting, turnaround
    output logic [1:0]  m_axis_tuser   // status
);

    state_t state_reg;
    state_t state_next;

    logic [SLOT_W-1:0]    cnt_reg;
    logic [SLOT_W-1:0]    cnt_next;
    logic                 op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [BURST_W-1:0]   burst_reg;
    logic [PRIO_W-1:0]    prio_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [SEQ_W-1:0]     seq_reg;
    cur_t                 cur_reg;

    logic                 m_valid_reg;
    logic [1:0]           status_reg;
    logic [ID_W-1:0]      run_id_reg;
    logic                 fin_reg;
    logic [ID_W-1:0]      fin_id_reg;
    logic [OUT_T_W-1:0]   resp_reg;
    logic [OUT_T_W-1:0]   wait_reg;
    logic [OUT_T_W-1:0]   turn_reg;

    logic                 in_xfer;
    logic                 act_fire;
    logic                 last_cnt;
    cand_t                best;
    cmd_t                 cmd;
    logic [SLOTS-1:0]     slot_valid;
    cand_t                chain [SLOTS+1];

    logic [TIME_BITS-1:0] time_inc;
    logic [TIME_BITS-1:0] first_t;
    logic [TIME_BITS-1:0] ta;
    logic [TIME_BITS-1:0] rs;
    logic [TIME_BITS-1:0] wt;
    logic                 finish;

    // cell chain
    assign chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        ppsu_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (SLOT_W'(g)),
            .cur        (cur_reg),
            .seq_now    (seq_reg),
            .cmd        (cmd),
            .cand_in    (chain[g]),
            .cand_out   (chain[g+1]),
            .slot_valid (slot_valid[g])
        );
    end

    assign best = chain[SLOTS];

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SWEEP;
                    cnt_next   = '0;
                end
            end
            ST_SWEEP:
            begin
                cnt_next = cnt_reg + SLOT_W'(1);
                if (last_cnt)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                if (act_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        act_fire      = (state_reg == ST_ACT) && (!m_valid_reg || m_axis_tready);
    end

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign last_cnt = (cnt_reg == SLOT_W'(SLOTS - 1));

    // timing figures of the chosen process
    assign finish   = (best.remaining == BURST_W'(1));
    assign time_inc = time_reg + TIME_BITS'(1);
    assign first_t  = best.started ? best.first : time_reg;
    assign ta       = time_inc - best.admit;
    assign rs       = first_t - best.admit;
    assign wt       = time_inc - best.admit - TIME_BITS'(best.burst);

    // update broadcast
    always_comb
    begin
        cmd          = '0;
        cmd.ident    = id_reg;
        cmd.burst    = (burst_reg == '0) ? BURST_W'(1) : burst_reg;
        cmd.prio     = prio_reg;
        cmd.time_now = time_reg;
        cmd.seq      = seq_reg;
        if (op_reg == OP_ADMIT)
        begin
            cmd.admit = act_fire && best.free_found;
            cmd.slot  = best.free_slot;
        end
        else
        begin
            cmd.run   = act_fire && best.best_found;
            cmd.slot  = best.slot;
        end
    end

    // FSM and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // hold the accepted item
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= s_axis_tuser;
            id_reg    <= s_axis_tdata[7:0];
            burst_reg <= s_axis_tdata[19:8];
            prio_reg  <= s_axis_tdata[27:20];
        end
    end

    // scheduler clock, admission count and running process
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            seq_reg  <= '0;
            cur_reg  <= '0;
        end
        else if (act_fire)
        begin
            if (op_reg == OP_ADMIT)
            begin
                if (best.free_found)
                begin
                    seq_reg <= seq_reg + SEQ_W'(1);
                end
            end
            else
            begin
                time_reg      <= time_inc;
                cur_reg.valid <= best.best_found && !finish;
                cur_reg.slot  <= best.slot;
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (act_fire)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (act_fire)
        begin
            run_id_reg <= '0;
            fin_reg    <= 1'b0;
            fin_id_reg <= '0;
            resp_reg   <= '0;
            wait_reg   <= '0;
            turn_reg   <= '0;
            if (op_reg == OP_ADMIT)
            begin
                status_reg <= best.free_found ? STAT_ADMIT : STAT_FULL;
            end
            else if (!best.best_found)
            begin
                status_reg <= STAT_IDLE;
            end
            else
            begin
                status_reg <= STAT_RAN;
                run_id_reg <= best.ident;
                if (finish)
                begin
                    fin_reg    <= 1'b1;
                    fin_id_reg <= best.ident;
                    resp_reg   <= OUT_T_W'(rs);
                    wait_reg   <= OUT_T_W'(wt);
                    turn_reg   <= OUT_T_W'(ta);
                end
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {7'd0, turn_reg, wait_reg, resp_reg, fin_id_reg, fin_reg,
                            run_id_reg};

    // checks
    `PPSU_ASSERT_NXT(a_sweep_after_xfer, in_xfer, state_reg == ST_SWEEP,
        "accepted item did not start a sweep")
    `PPSU_ASSERT_IMP(a_cur_occupied, cur_reg.valid, slot_valid[cur_reg.slot],
        "running process points at an empty slot")
    `PPSU_ASSERT_IMP(a_finish_is_run, m_valid_reg && fin_reg, status_reg == STAT_RAN,
        "finish reported without a run")
    `PPSU_ASSERT_NXT(a_act_loads_out, act_fire, m_valid_reg,
        "result not loaded by the update cycle")

endmodule
